// File: rtl/lzrle_pkg.sv
// Package for the LZ/RLE byte decompressor: defaults, command codes and window tables.
package lzrle_pkg;

  // Parameter defaults
  localparam int HISTORY_BYTES_DEF    = 65536;
  localparam int BYTES_PER_RESULT_DEF = 4;

  // Saturation limit of the output length counter
  localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

  // Window size after reset and after the end command
  localparam logic [15:0] WINDOW_RESET = 16'd4;

  // Command codes and field masks
  localparam logic [7:0] CMD_SET_WIN = 8'h80;
  localparam logic [7:0] CMD_LIT     = 8'hA0;
  localparam logic [7:0] CMD_FILL    = 8'hC0;
  localparam logic [7:0] CMD_ZERO    = 8'hD0;
  localparam logic [7:0] CMD_REP16   = 8'hE0;
  localparam logic [7:0] CMD_REP     = 8'hF0;
  localparam logic [7:0] CMD_END     = 8'hFF;
  localparam logic [7:0] MASK_LONG   = 8'h1F;
  localparam logic [7:0] MASK_SHORT  = 8'h0F;

  // Short copy: distance = window * WIN_MUL[k] + WIN_OFS[k]
  localparam logic [1:0] WIN_MUL [8] = '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic signed [2:0] WIN_OFS [8] =
    '{-3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2, -3'sd1, 3'sd0, 3'sd1};

endpackage

// File: rtl/lz_rle_byte_decompressor.sv
// LZ/RLE byte decompressor: parser, byte sequencer, history RAM and result packing.
//
// One compressed byte is taken per transfer while the block is idle; in_stall is high
// for the whole time that the byte's output is being produced. A byte that only stores
// an operand or selects a parser phase leaves the block idle. A byte that produces output
// is decoded as it is taken; a setup state then does the distance check and total length,
// and each byte copied from history passes a registered RAM read followed by the write of
// the same byte, which keeps overlapping copies exact, while each fill, zero, literal or
// out-of-history byte is written alone. Each packed result is handed to the output
// register, which out_stall can hold full. The history RAM is a single-port style array
// of HISTORY_BYTES bytes, read at one address and written at one address; it is not
// cleared, and copies are checked against the length written so far, so no start-up
// pass is needed. The end command gives one result with out_stream_end set and returns
// the length, window and parser to their reset values.
module lz_rle_byte_decompressor #(
  parameter int HISTORY_BYTES    = lzrle_pkg::HISTORY_BYTES_DEF,
  parameter int BYTES_PER_RESULT = lzrle_pkg::BYTES_PER_RESULT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // compressed byte channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             in_compressed_byte,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [8*BYTES_PER_RESULT-1:0]          out_bytes,
  output logic [$clog2(BYTES_PER_RESULT+1)-1:0]  out_byte_count,
  output logic                                   out_last_of_run,
  output logic                                   out_stream_end,
  output logic [23:0]                            out_total_length,
  output logic                                   out_bad_reference
);

  localparam int PW = $clog2(HISTORY_BYTES);
  localparam int CW = ($clog2(HISTORY_BYTES + 1) > 24) ? $clog2(HISTORY_BYTES + 1) + 1 : 25;
  localparam int BW = 8 * BYTES_PER_RESULT;
  localparam int KW = $clog2(BYTES_PER_RESULT + 1);
  localparam int IW = $clog2(BYTES_PER_RESULT);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // parser phases
  localparam logic [2:0] PH_CMD    = 3'd0;
  localparam logic [2:0] PH_WIN_HI = 3'd1;
  localparam logic [2:0] PH_WIN_LO = 3'd2;
  localparam logic [2:0] PH_DIST   = 3'd3;
  localparam logic [2:0] PH_FILL   = 3'd4;
  localparam logic [2:0] PH_LIT    = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic [5:0]         lit_left_r, lit_left_nxt;
  logic [7:0]         win_hi_r, win_hi_nxt;
  logic [15:0]        win_r, win_nxt;
  logic [23:0]        outpos_r, outpos_nxt;
  logic [PW-1:0]      wp_r, wp_nxt;
  logic [PW-1:0]      rp_r, rp_nxt;
  logic               copy_r, copy_nxt;
  logic [7:0]         val_r, val_nxt;
  logic signed [18:0] dist_r, dist_nxt;
  logic [8:0]         cnt_r, cnt_nxt;
  logic [23:0]        total_r, total_nxt;
  logic               bad_r, bad_nxt;
  logic               end_r, end_nxt;
  logic [BW-1:0]      pack_r, pack_nxt;
  logic [KW-1:0]      pack_cnt_r, pack_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [BW-1:0]      out_bytes_r, out_bytes_nxt;
  logic [KW-1:0]      out_cnt_r, out_cnt_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_end_r, out_end_nxt;
  logic [23:0]        out_total_r, out_total_nxt;
  logic               out_bad_r, out_bad_nxt;

  logic [7:0]         hist_mem [HISTORY_BYTES];
  logic [7:0]         rdata_r;

  // working signals
  logic [7:0]         b;
  logic [2:0]         k;
  logic [18:0]        win_base;
  logic               dist_pos;
  logic [CW-1:0]      dist_u;
  logic               dist_ok;
  logic [CW-1:0]      rd_sum;
  logic [CW-1:0]      tot_sum;
  logic [PW:0]        wp_inc;
  logic [PW:0]        rp_inc;
  logic [7:0]         put_byte;
  logic               out_free;
  logic               pack_full;

  assign b         = in_compressed_byte;
  assign k         = b[6:4];
  assign put_byte  = copy_r ? rdata_r : val_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign pack_full = (pack_cnt_r == KW'(BYTES_PER_RESULT - 1));
  assign wp_inc    = {1'b0, wp_r} + 1'b1;
  assign rp_inc    = {1'b0, rp_r} + 1'b1;

  // window product for short copies
  assign win_base = (lzrle_pkg::WIN_MUL[k] == 2'd2) ? {2'b00, win_r, 1'b0} : {3'b000, win_r};

  // distance check, read start address and final length
  assign dist_pos = !dist_r[18] && (dist_r != '0);
  assign dist_u   = CW'(dist_r[17:0]);
  assign dist_ok  = dist_pos && (dist_u <= CW'(outpos_r)) && (dist_u <= CW'(HISTORY_BYTES));
  assign rd_sum   = CW'(wp_r) + CW'(HISTORY_BYTES) - dist_u;
  assign tot_sum  = CW'(outpos_r) + CW'(cnt_r);

  // sequencer and parser
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    lit_left_nxt  = lit_left_r;
    win_hi_nxt    = win_hi_r;
    win_nxt       = win_r;
    outpos_nxt    = outpos_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    copy_nxt      = copy_r;
    val_nxt       = val_r;
    dist_nxt      = dist_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    bad_nxt       = bad_r;
    end_nxt       = end_r;
    pack_nxt      = pack_r;
    pack_cnt_nxt  = pack_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bytes_nxt = out_bytes_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    out_total_nxt = out_total_r;
    out_bad_nxt   = out_bad_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (phase_r)
            PH_WIN_HI: begin
              win_hi_nxt = b;
              phase_nxt  = PH_WIN_LO;
            end
            PH_WIN_LO: begin
              win_nxt   = {win_hi_r, b};
              phase_nxt = PH_CMD;
            end
            PH_DIST: begin
              phase_nxt = PH_CMD;
              copy_nxt  = 1'b1;
              dist_nxt  = $signed({11'd0, b});
              cnt_nxt   = {4'd0, pend_r[4:0]} + 9'd1;
              state_nxt = S_SETUP;
            end
            PH_FILL: begin
              phase_nxt = PH_CMD;
              copy_nxt  = 1'b0;
              val_nxt   = b;
              cnt_nxt   = {5'd0, pend_r[3:0]} + 9'd2;
              state_nxt = S_SETUP;
            end
            PH_LIT: begin
              copy_nxt     = 1'b0;
              val_nxt      = b;
              cnt_nxt      = 9'd1;
              lit_left_nxt = lit_left_r - 6'd1;
              if (lit_left_r == 6'd1) begin
                phase_nxt = PH_CMD;
              end
              state_nxt = S_SETUP;
            end
            default: begin
              phase_nxt = PH_CMD;
              priority if (b == lzrle_pkg::CMD_END) begin
                // end of stream: one marker result, then back to reset values
                pack_nxt     = '0;
                pack_cnt_nxt = '0;
                cnt_nxt      = '0;
                end_nxt      = 1'b1;
                bad_nxt      = 1'b0;
                total_nxt    = outpos_r;
                outpos_nxt   = '0;
                wp_nxt       = '0;
                win_nxt      = lzrle_pkg::WINDOW_RESET;
                pend_nxt     = '0;
                lit_left_nxt = '0;
                win_hi_nxt   = '0;
                state_nxt    = S_EMIT;
              end else if (b < lzrle_pkg::CMD_SET_WIN) begin
                copy_nxt  = 1'b1;
                dist_nxt  = $signed(win_base) + 19'(lzrle_pkg::WIN_OFS[k]);
                cnt_nxt   = {5'd0, b[3:0]} + 9'd1;
                state_nxt = S_SETUP;
              end else if (b == lzrle_pkg::CMD_SET_WIN) begin
                phase_nxt = PH_WIN_HI;
              end else if (b < lzrle_pkg::CMD_LIT) begin
                pend_nxt  = b;
                phase_nxt = PH_DIST;
              end else if (b < lzrle_pkg::CMD_FILL) begin
                lit_left_nxt = {1'b0, b[4:0] & lzrle_pkg::MASK_LONG[4:0]} + 6'd1;
                phase_nxt    = PH_LIT;
              end else if (b < lzrle_pkg::CMD_ZERO) begin
                pend_nxt  = b;
                phase_nxt = PH_FILL;
              end else if (b < lzrle_pkg::CMD_REP16) begin
                copy_nxt  = 1'b0;
                val_nxt   = 8'd0;
                cnt_nxt   = {5'd0, b[3:0]} + 9'd1;
                state_nxt = S_SETUP;
              end else begin
                // repeat of the last byte, sixteen per count below the short form
                copy_nxt  = 1'b1;
                dist_nxt  = 19'sd1;
                if (b < lzrle_pkg::CMD_REP) begin
                  cnt_nxt = {({1'b0, b[3:0] & lzrle_pkg::MASK_SHORT[3:0]} + 5'd1), 4'd0};
                end else begin
                  cnt_nxt = {5'd0, b[3:0]} + 9'd1;
                end
                state_nxt = S_SETUP;
              end
            end
          endcase
        end
      end

      S_SETUP: begin
        end_nxt   = 1'b0;
        total_nxt = (tot_sum > CW'(lzrle_pkg::LEN_MAX)) ? lzrle_pkg::LEN_MAX : tot_sum[23:0];
        bad_nxt   = copy_r && !dist_ok;
        rp_nxt    = (rd_sum >= CW'(HISTORY_BYTES)) ? PW'(rd_sum - CW'(HISTORY_BYTES))
                                                   : PW'(rd_sum);
        if (copy_r && !dist_ok) begin
          // out-of-history copy reads as zeros
          copy_nxt  = 1'b0;
          val_nxt   = 8'd0;
          state_nxt = S_PUT;
        end else if (copy_r) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_READ: begin
        state_nxt = S_PUT;
      end

      S_PUT: begin
        wp_nxt  = (wp_inc >= (PW+1)'(HISTORY_BYTES)) ? '0 : wp_inc[PW-1:0];
        rp_nxt  = (rp_inc >= (PW+1)'(HISTORY_BYTES)) ? '0 : rp_inc[PW-1:0];
        cnt_nxt = cnt_r - 9'd1;
        if (outpos_r != lzrle_pkg::LEN_MAX) begin
          outpos_nxt = outpos_r + 24'd1;
        end
        pack_nxt[8*pack_cnt_r[IW-1:0] +: 8] = put_byte;
        pack_cnt_nxt = pack_cnt_r + 1'b1;
        if (pack_full || cnt_r == 9'd1) begin
          state_nxt = S_EMIT;
        end else if (copy_r) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = pack_r;
          out_cnt_nxt   = pack_cnt_r;
          out_last_nxt  = (cnt_r == 9'd0);
          out_end_nxt   = end_r;
          out_total_nxt = total_r;
          out_bad_nxt   = bad_r;
          pack_nxt      = '0;
          pack_cnt_nxt  = '0;
          if (cnt_r == 9'd0) begin
            state_nxt = S_IDLE;
          end else if (copy_r) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_CMD;
      pend_r      <= '0;
      lit_left_r  <= '0;
      win_hi_r    <= '0;
      win_r       <= lzrle_pkg::WINDOW_RESET;
      outpos_r    <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      end_r       <= 1'b0;
      pack_r      <= '0;
      pack_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      lit_left_r  <= lit_left_nxt;
      win_hi_r    <= win_hi_nxt;
      win_r       <= win_nxt;
      outpos_r    <= outpos_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      end_r       <= end_nxt;
      pack_r      <= pack_nxt;
      pack_cnt_r  <= pack_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r        <= rp_nxt;
    copy_r      <= copy_nxt;
    val_r       <= val_nxt;
    dist_r      <= dist_nxt;
    total_r     <= total_nxt;
    bad_r       <= bad_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
    out_end_r   <= out_end_nxt;
    out_total_r <= out_total_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  // history RAM: a write in the put state and a registered read in the read state
  always_ff @(posedge clk) begin
    if (state_r == S_PUT) begin
      hist_mem[wp_r] <= put_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rdata_r <= hist_mem[rp_r];
    end
  end

  // ports
  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_bytes         = out_bytes_r;
  assign out_byte_count    = out_cnt_r;
  assign out_last_of_run   = out_last_r;
  assign out_stream_end    = out_end_r;
  assign out_total_length  = out_total_r;
  assign out_bad_reference = out_bad_r;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the LZ/RLE byte decompressor: stimulus, byte-level predictor and checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_BYTES   = lzrle_pkg::HISTORY_BYTES_DEF;
  localparam int RESULT_BYTES = lzrle_pkg::BYTES_PER_RESULT_DEF;
  localparam int COUNT_W      = $clog2(RESULT_BYTES + 1);
  localparam int QUIET_LIMIT  = 2000;

  // short copy: distance = window * mult + offset, indexed by command bits 6:4
  localparam int WIN_MULT [8]   = '{1, 1, 1, 1, 1, 2, 2, 2};
  localparam int WIN_OFFSET [8] = '{-2, -1, 0, 1, 2, -1, 0, 1};

  typedef enum logic [2:0] {
    PH_COMMAND, PH_WINDOW_HI, PH_WINDOW_LO, PH_DISTANCE, PH_FILL_BYTE, PH_LITERAL
  } parse_phase_t;

  typedef struct packed {
    logic [8*RESULT_BYTES-1:0] bytes;
    logic [COUNT_W-1:0]        count;
    logic                      last_run;
    logic                      stream_end;
    logic [23:0]               total_len;
    logic                      bad_ref;
  } decoded_word_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                in_compressed_byte = 8'h00;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [8*RESULT_BYTES-1:0] out_bytes;
  logic [COUNT_W-1:0]        out_byte_count;
  logic                      out_last_of_run;
  logic                      out_stream_end;
  logic [23:0]               out_total_length;
  logic                      out_bad_reference;

  // decoder model state
  logic [7:0]    hist_mem [HIST_BYTES];
  logic [23:0]   out_pos;
  int            wr_ptr;
  logic [15:0]   window_len;
  parse_phase_t  phase;
  logic [7:0]    pend_cmd;
  logic [5:0]    lit_left;
  logic [7:0]    win_hi;
  logic [7:0]    step_bytes [$];
  bit            step_bad;

  decoded_word_t expected_words [$];
  int            mismatches = 0;
  int            items_sent = 0;
  int            quiet_cycles = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;

  lz_rle_byte_decompressor #(
    .HISTORY_BYTES    (HIST_BYTES),
    .BYTES_PER_RESULT (RESULT_BYTES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_compressed_byte (in_compressed_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bytes          (out_bytes),
    .out_byte_count     (out_byte_count),
    .out_last_of_run    (out_last_of_run),
    .out_stream_end     (out_stream_end),
    .out_total_length   (out_total_length),
    .out_bad_reference  (out_bad_reference)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // back to the start of a stream; history contents are kept
  function automatic void reset_decoder();
    out_pos    = '0;
    wr_ptr     = 0;
    window_len = lzrle_pkg::WINDOW_RESET;
    phase      = PH_COMMAND;
    pend_cmd   = '0;
    lit_left   = '0;
    win_hi     = '0;
  endfunction

  function automatic void put_out_byte(logic [7:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % HIST_BYTES;
    if (out_pos != lzrle_pkg::LEN_MAX) out_pos = out_pos + 1'b1;
    step_bytes.push_back(b);
  endfunction

  // distance outside written history: flag it and read zeros
  function automatic void copy_history(int distance, int count);
    bit ok;
    logic [7:0] b;
    ok = distance >= 1 && distance <= int'(out_pos) && distance <= HIST_BYTES;
    if (!ok) step_bad = 1'b1;
    repeat (count) begin
      b = ok ? hist_mem[(wr_ptr + HIST_BYTES - distance) % HIST_BYTES] : 8'h00;
      put_out_byte(b);
    end
  endfunction

  function automatic void decode_command(logic [7:0] c);
    int k;
    k = int'(c[6:4]);
    if (c < lzrle_pkg::CMD_SET_WIN) begin
      copy_history(int'(window_len) * WIN_MULT[k] + WIN_OFFSET[k],
                   int'(c & lzrle_pkg::MASK_SHORT) + 1);
    end else if (c == lzrle_pkg::CMD_SET_WIN) begin
      phase = PH_WINDOW_HI;
    end else if (c < lzrle_pkg::CMD_LIT) begin
      pend_cmd = c;
      phase = PH_DISTANCE;
    end else if (c < lzrle_pkg::CMD_FILL) begin
      lit_left = 6'(int'(c & lzrle_pkg::MASK_LONG) + 1);
      phase = PH_LITERAL;
    end else if (c < lzrle_pkg::CMD_ZERO) begin
      pend_cmd = c;
      phase = PH_FILL_BYTE;
    end else if (c < lzrle_pkg::CMD_REP16) begin
      repeat (int'(c & lzrle_pkg::MASK_SHORT) + 1) put_out_byte(8'h00);
    end else if (c < lzrle_pkg::CMD_REP) begin
      copy_history(1, 16 * (int'(c & lzrle_pkg::MASK_SHORT) + 1));
    end else begin
      copy_history(1, int'(c & lzrle_pkg::MASK_SHORT) + 1);
    end
  endfunction

  // works out the results caused by one accepted byte and queues them
  function automatic void predict_byte(logic [7:0] b);
    decoded_word_t w;
    int nres, cnt, ri, i;
    step_bytes.delete();
    step_bad = 1'b0;
    w = '0;
    if (phase == PH_COMMAND && b == lzrle_pkg::CMD_END) begin
      w.last_run   = 1'b1;
      w.stream_end = 1'b1;
      w.total_len  = out_pos;
      expected_words.push_back(w);
      reset_decoder();
    end else begin
      case (phase)
        PH_WINDOW_HI: begin
          win_hi = b;
          phase = PH_WINDOW_LO;
        end
        PH_WINDOW_LO: begin
          window_len = {win_hi, b};
          phase = PH_COMMAND;
        end
        PH_DISTANCE: begin
          phase = PH_COMMAND;
          copy_history(int'(b), int'(pend_cmd & lzrle_pkg::MASK_LONG) + 1);
        end
        PH_FILL_BYTE: begin
          phase = PH_COMMAND;
          repeat (int'(pend_cmd & lzrle_pkg::MASK_SHORT) + 2) put_out_byte(b);
        end
        PH_LITERAL: begin
          put_out_byte(b);
          lit_left = lit_left - 1'b1;
          if (lit_left == '0) phase = PH_COMMAND;
        end
        default: begin
          decode_command(b);
        end
      endcase
      // pack the produced bytes, first byte lowest
      nres = (step_bytes.size() + RESULT_BYTES - 1) / RESULT_BYTES;
      for (ri = 0; ri < nres; ri++) begin
        w = '0;
        cnt = step_bytes.size() - ri * RESULT_BYTES;
        if (cnt > RESULT_BYTES) cnt = RESULT_BYTES;
        for (i = 0; i < cnt; i++) w.bytes[8*i +: 8] = step_bytes[ri * RESULT_BYTES + i];
        w.count     = COUNT_W'(cnt);
        w.last_run  = (ri == nres - 1);
        w.total_len = out_pos;
        w.bad_ref   = step_bad;
        expected_words.push_back(w);
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // each result transfer against the oldest expectation
  always @(posedge clk) begin
    decoded_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual bytes %0h count %0d",
                 $time, out_bytes, out_byte_count);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        compare_field("bytes", 64'(want.bytes), 64'(out_bytes));
        compare_field("byte_count", 64'(want.count), 64'(out_byte_count));
        compare_field("last_of_run", 64'(want.last_run), 64'(out_last_of_run));
        compare_field("stream_end", 64'(want.stream_end), 64'(out_stream_end));
        compare_field("total_length", 64'(want.total_len), 64'(out_total_length));
        compare_field("bad_reference", 64'(want.bad_ref), 64'(out_bad_reference));
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  // one byte transfer; valid stays high afterwards unless the next call idles
  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_compressed_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(value);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // one well-formed command with random content, or a stray byte now and then
  task automatic send_random_command();
    int kind, n;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_byte(8'($urandom_range(255)));
    end else if (kind < 24) begin
      send_byte(8'($urandom_range(8'h7F)));
    end else if (kind < 32) begin
      send_byte(lzrle_pkg::CMD_SET_WIN);
      if ($urandom_range(3) == 0) begin
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(8'h00);
        send_byte(8'($urandom_range(16)));
      end
    end else if (kind < 46) begin
      send_byte(lzrle_pkg::CMD_SET_WIN + 8'($urandom_range(1, 31)));
      send_byte(8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(1, 24)));
    end else if (kind < 62) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3);
      send_byte(lzrle_pkg::CMD_LIT | 8'(n));
      repeat (n + 1) send_byte(8'($urandom_range(255)));
    end else if (kind < 72) begin
      send_byte(lzrle_pkg::CMD_FILL | 8'($urandom_range(15)));
      send_byte(8'($urandom_range(255)));
    end else if (kind < 80) begin
      send_byte(lzrle_pkg::CMD_ZERO | 8'($urandom_range(15)));
    end else if (kind < 86) begin
      send_byte(lzrle_pkg::CMD_REP16 |
                8'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(1)));
    end else if (kind < 96) begin
      send_byte(lzrle_pkg::CMD_REP + 8'($urandom_range(14)));
    end else begin
      send_byte(lzrle_pkg::CMD_END);
    end
  endtask

  // every command class, field extremes, bad distances, zero and maximum window
  task automatic test_directed_commands();
    send_byte(lzrle_pkg::CMD_REP);                            // repeat with nothing written yet
    send_byte(lzrle_pkg::CMD_LIT | 8'h03);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h20);                                         // copy from one window back
    send_byte(8'h7F);                                         // reaches past written history
    send_byte(lzrle_pkg::CMD_SET_WIN);                        // window of zero
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h35);                                         // offset alone gives distance 1
    send_byte(8'h00);                                         // distance below 1
    send_byte(lzrle_pkg::CMD_SET_WIN | 8'h01);                // far copy, distance 0
    send_byte(8'h00);
    send_byte(lzrle_pkg::CMD_SET_WIN | lzrle_pkg::MASK_LONG); // longest far copy, overlapping
    send_byte(8'h03);
    send_byte(lzrle_pkg::CMD_FILL);
    send_byte(8'hFF);
    send_byte(lzrle_pkg::CMD_ZERO | lzrle_pkg::MASK_SHORT);
    send_byte(lzrle_pkg::CMD_REP16 | lzrle_pkg::MASK_SHORT);  // 256 repeats
    send_byte(lzrle_pkg::CMD_SET_WIN);                        // largest window
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h50);                                         // distance beyond the history size
    send_byte(lzrle_pkg::CMD_END);
  endtask

  task automatic test_random_stream(int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) send_random_command();
  endtask

  // sender holds off until the block has handed over every result
  task automatic test_drain_pause();
    repeat (3) begin
      send_random_command();
      wait_for_results();
    end
  endtask

  initial begin
    reset_decoder();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 68;
    test_directed_commands();
    test_random_stream(30);
    test_drain_pause();

    send_idle_pct = 68;
    recv_idle_pct = 33;
    test_random_stream(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(30);

    // drain, then allow for any late or extra result
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
